>>> design/spq_pkg.sv
// shared types and constants for the stable priority queue
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ID_W = 16;
   localparam int PRIO_W = 3;

   localparam logic [PRIO_W-1:0] PRIO_MAX = 3'd5;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LIST   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_ROTATE
   } op_type;

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [CNT_W-1:0]  count;
   } cmd_type;

endpackage

>>> design/stable_priority_queue.sv
// stable priority queue of task ids built from a row of shifting cells
//
// A request on req_* inserts a task id with a priority, removes the first
// entry with an id, or lists the queue. Results leave on rsp_*, each with
// rsp_last set on the final result of its request.
// Insert and remove finish in the cycle the request is taken; the result is
// registered and shows in the next cycle. With rsp_ready high the block takes
// one insert or remove request every cycle.
// A list of n entries rotates the cell row once per result, so it emits one
// entry per cycle while rsp_ready is high; req_ready stays low until the final
// result has been registered. An empty queue gives one result with status empty.
// Mode 3 is taken and dropped with no result.
// Reset empties the queue and drops any pending result; no clearing pass.
// When the receiver stalls, the result holds and no new request is taken,
// and a list in progress pauses its rotation.
`timescale 1ns / 1ps

module stable_priority_queue
   import spq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [ID_W-1:0]   req_task_id,
   input  logic [PRIO_W-1:0] req_prio,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_entry_id,
   output logic [PRIO_W-1:0] rsp_entry_prio,
   output logic              rsp_last
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  list_idx_ff, list_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff, status_in;
   logic [ID_W-1:0]   entry_id_ff, entry_id_in;
   logic [PRIO_W-1:0] entry_prio_ff, entry_prio_in;
   logic              last_ff, last_in;

   cmd_type   cmd;
   entry_type head;
   logic      found;
   logic      out_free;
   logic      accept;
   logic      list_last;

   spq_chain u_chain (
      .clock (clock),
      .cmd   (cmd),
      .head  (head),
      .found (found)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         list_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         list_idx_ff  <= list_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      entry_id_ff   <= entry_id_in;
      entry_prio_ff <= entry_prio_in;
      last_ff       <= last_in;
   end

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == S_IDLE) && out_free;
      accept    = req_valid && req_ready;
      list_last = CNT_W'(list_idx_ff) == count_ff - CNT_W'(1);

      cmd.op    = OP_HOLD;
      cmd.id    = req_task_id;
      cmd.prio  = (req_prio > PRIO_MAX) ? PRIO_MAX : req_prio;
      cmd.count = count_ff;

      state_in      = state_ff;
      count_in      = count_ff;
      list_idx_in   = list_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      entry_id_in   = entry_id_ff;
      entry_prio_in = entry_prio_ff;
      last_in       = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               entry_id_in   = req_task_id;
               entry_prio_in = '0;
               last_in       = 1'b1;
               status_in     = ST_OK;
               case (req_mode)
                  MODE_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.op   = OP_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (!found) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        cmd.op   = OP_REMOVE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  MODE_LIST: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_EMPTY;
                     end else begin
                        state_in    = S_LIST;
                        list_idx_in = '0;
                     end
                  end
                  default: begin
                     status_in = status_ff;
                  end
               endcase
            end
         end
         S_LIST: begin
            if (out_free) begin
               cmd.op        = OP_ROTATE;
               rsp_valid_in  = 1'b1;
               status_in     = ST_OK;
               entry_id_in   = head.id;
               entry_prio_in = head.prio;
               last_in       = list_last;
               list_idx_in   = list_idx_ff + IDX_W'(1);
               if (list_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_entry_id   = entry_id_ff;
   assign rsp_entry_prio = entry_prio_ff;
   assign rsp_last       = last_ff;

endmodule

>>> design/spq_cell.sv
// one queue slot: holds an entry and shifts it to or from its neighbors
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] cell_idx,
   input  entry_type        left_entry,
   input  entry_type        right_entry,
   input  entry_type        head_entry,
   input  logic             keep_left,
   input  logic             hit_left,
   output logic             keep_out,
   output logic             hit_out,
   output entry_type        entry_out
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;
   logic      match;

   always_comb begin
      occupied = CNT_W'(cell_idx) < cmd.count;
      keep_out = occupied && (entry_ff.prio >= cmd.prio);
      match    = occupied && (entry_ff.id == cmd.id);
      hit_out  = hit_left || match;
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (!keep_out) begin
               if (keep_left) begin
                  entry_in.id   = cmd.id;
                  entry_in.prio = cmd.prio;
               end else begin
                  entry_in = left_entry;
               end
            end
         end
         OP_REMOVE: begin
            if (hit_out) begin
               entry_in = right_entry;
            end
         end
         OP_ROTATE: begin
            if (CNT_W'(cell_idx) == cmd.count - CNT_W'(1)) begin
               entry_in = head_entry;
            end else begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

>>> design/spq_chain.sv
// row of queue cells, head at index zero
`timescale 1ns / 1ps

module spq_chain
   import spq_pkg::*;
(
   input  logic      clock,
   input  cmd_type   cmd,
   output entry_type head,
   output logic      found
);

   entry_type entries [DEPTH];
   logic      keeps   [DEPTH];
   logic      hits    [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      keep_l;
      logic      hit_l;

      if (i == 0) begin : g_first
         assign left_e = '0;
         assign keep_l = 1'b1;
         assign hit_l  = 1'b0;
      end else begin : g_mid
         assign left_e = entries[i-1];
         assign keep_l = keeps[i-1];
         assign hit_l  = hits[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_idx    (IDX_W'(i)),
         .left_entry  (left_e),
         .right_entry (right_e),
         .head_entry  (entries[0]),
         .keep_left   (keep_l),
         .hit_left    (hit_l),
         .keep_out    (keeps[i]),
         .hit_out     (hits[i]),
         .entry_out   (entries[i])
      );
   end

   assign head  = entries[0];
   assign found = hits[DEPTH-1];

endmodule

>>> design/spq_checker.sv
// port-level checks for the stable priority queue
`timescale 1ns / 1ps

module spq_checker
   import spq_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_mode,
   input logic [ID_W-1:0]   req_task_id,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [ID_W-1:0]   rsp_entry_id,
   input logic [PRIO_W-1:0] rsp_entry_prio,
   input logic              rsp_last
);

   // no valid result after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_id) && $stable(rsp_entry_prio) && $stable(rsp_last))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   // insert answers in the next cycle with a single result echoing the id
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_INSERT |=>
         rsp_valid && rsp_last && rsp_entry_prio == '0
         && rsp_entry_id == $past(req_task_id)
         && (rsp_status == ST_OK || rsp_status == ST_FULL))
      else $error("bad insert result");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_REMOVE |=>
         rsp_valid && rsp_last && rsp_status != ST_FULL
         && rsp_entry_id == $past(req_task_id))
      else $error("bad remove result");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

>>> dv/testbench.sv
// testbench for the stable priority queue: scoreboard class, random requests and stalls
`timescale 1ns / 1ps

import spq_pkg::*;

typedef struct packed {
   logic [1:0]        status;
   logic [ID_W-1:0]   id;
   logic [PRIO_W-1:0] prio;
   logic              last;
} queue_rsp_type;

class queue_scoreboard;
   logic [ID_W-1:0]   ids [DEPTH];
   logic [PRIO_W-1:0] prios [DEPTH];
   int                fill;
   queue_rsp_type     pending [$];
   int                mismatches;

   function new();
      fill = 0;
      mismatches = 0;
   endfunction

   function void add_result(logic [1:0] status, logic [ID_W-1:0] id,
                            logic [PRIO_W-1:0] prio, logic last);
      queue_rsp_type r;
      r.status = status;
      r.id = id;
      r.prio = prio;
      r.last = last;
      pending.push_back(r);
   endfunction

   // update the queue copy and line up the results of one accepted request
   function void note_request(logic [1:0] mode, logic [ID_W-1:0] id,
                              logic [PRIO_W-1:0] prio);
      logic [PRIO_W-1:0] p;
      int pos;
      p = (prio > PRIO_MAX) ? PRIO_MAX : prio;
      pos = 0;
      case (mode)
         MODE_INSERT: begin
            if (fill >= DEPTH) begin
               add_result(ST_FULL, id, '0, 1'b1);
            end else begin
               while (pos < fill && prios[pos] >= p) pos++;
               for (int i = fill; i > pos; i--) begin
                  ids[i] = ids[i-1];
                  prios[i] = prios[i-1];
               end
               ids[pos] = id;
               prios[pos] = p;
               fill++;
               add_result(ST_OK, id, '0, 1'b1);
            end
         end
         MODE_REMOVE: begin
            if (fill == 0) begin
               add_result(ST_EMPTY, id, '0, 1'b1);
            end else begin
               while (pos < fill && ids[pos] != id) pos++;
               if (pos >= fill) begin
                  add_result(ST_NOT_FOUND, id, '0, 1'b1);
               end else begin
                  for (int i = pos; i + 1 < fill; i++) begin
                     ids[i] = ids[i+1];
                     prios[i] = prios[i+1];
                  end
                  fill--;
                  add_result(ST_OK, id, '0, 1'b1);
               end
            end
         end
         MODE_LIST: begin
            if (fill == 0) begin
               add_result(ST_EMPTY, id, '0, 1'b1);
            end else begin
               for (int i = 0; i < fill; i++)
                  add_result(ST_OK, ids[i], prios[i], i == fill - 1);
            end
         end
         default: ;
      endcase
   endfunction

   function void check_response(logic [1:0] status, logic [ID_W-1:0] id,
                                logic [PRIO_W-1:0] prio, logic last);
      queue_rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: status %0d id %h prio %0d last %0b",
                     status, id, prio, last);
         return;
      end
      want = pending.pop_front();
      if (status !== want.status || id !== want.id || prio !== want.prio
          || last !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch: expected status %0d id %h prio %0d last %0b, %s",
                     want.status, want.id, want.prio, want.last,
                     $sformatf("got status %0d id %h prio %0d last %0b",
                               status, id, prio, last));
      end
   endfunction
endclass

module testbench;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_ITEMS = 185;
   localparam int PHASE_ITEMS = 35;
   localparam int TAIL_CYCLES = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic [1:0]        req_mode = MODE_INSERT;
   logic [ID_W-1:0]   req_task_id = '0;
   logic [PRIO_W-1:0] req_prio = '0;
   logic              rsp_ready = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [ID_W-1:0]   rsp_entry_id;
   logic [PRIO_W-1:0] rsp_entry_prio;
   logic              rsp_last;

   queue_scoreboard sb = new();
   int burst_left = 0;
   bit long_hold_wanted = 1'b0;

   stable_priority_queue u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_task_id    (req_task_id),
      .req_prio       (req_prio),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_entry_id   (rsp_entry_id),
      .rsp_entry_prio (rsp_entry_prio),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_request(logic [1:0] mode, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_task_id <= id;
      req_prio <= prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(mode, id, prio);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
      end
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      if (r < 40) return ID_W'($urandom_range(1, 10));
      if (r < 70 && sb.fill > 0) return sb.ids[$urandom_range(0, sb.fill - 1)];
      return ID_W'($urandom);
   endfunction

   function automatic logic [1:0] pick_mode(bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return MODE_UNUSED;
      if (r < 15) return MODE_LIST;
      if (filling) return (r < 70) ? MODE_INSERT : MODE_REMOVE;
      return (r < 35) ? MODE_INSERT : MODE_REMOVE;
   endfunction

   // stimulus
   initial begin
      int sent;
      logic [1:0] mode;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(MODE_LIST, 16'hA5A5, 3'd0);
      send_request(MODE_REMOVE, 16'hFFFF, 3'd7);
      send_request(MODE_UNUSED, 16'h5A5A, 3'd2);
      send_request(MODE_INSERT, 16'h0000, 3'd7);
      send_request(MODE_INSERT, 16'hFFFF, 3'd0);
      send_request(MODE_INSERT, 16'h1234, 3'd6);
      send_request(MODE_INSERT, 16'h1234, 3'd5);
      send_request(MODE_INSERT, 16'h0042, 3'd5);
      send_request(MODE_INSERT, 16'h0007, 3'd3);
      send_request(MODE_LIST, 16'h0000, 3'd0);
      send_request(MODE_REMOVE, 16'h1234, 3'd0);
      send_request(MODE_REMOVE, 16'hBEEF, 3'd0);
      send_request(MODE_UNUSED, 16'hFFFF, 3'd7);
      send_request(MODE_LIST, 16'hFFFF, 3'd7);
      send_request(MODE_REMOVE, 16'h0000, 3'd0);
      send_request(MODE_REMOVE, 16'h1234, 3'd0);
      send_request(MODE_REMOVE, 16'h0042, 3'd0);
      send_request(MODE_REMOVE, 16'h0007, 3'd0);
      send_request(MODE_REMOVE, 16'hFFFF, 3'd0);
      send_request(MODE_LIST, 16'h0F0F, 3'd0);
      send_request(MODE_REMOVE, 16'h0007, 3'd0);

      long_hold_wanted = 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = pick_mode(((sent / PHASE_ITEMS) % 2) == 0);
         send_request(mode, pick_id(), PRIO_W'($urandom_range(0, 7)));
         if (mode != MODE_UNUSED) sent++;
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // receiver stall pattern
   initial begin
      int style;
      int style_left;
      int run_left;
      bit level;
      style = 0;
      style_left = 0;
      run_left = 0;
      level = 1'b1;
      forever begin
         @(posedge clock);
         if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (style_left == 0) begin
            style = $urandom_range(0, 2);
            style_left = $urandom_range(20, 80);
         end
         style_left--;
         case (style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: begin
               if (run_left == 0) begin
                  level = ~level;
                  run_left = $urandom_range(1, 8);
               end
               run_left--;
               rsp_ready <= level;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_entry_id, rsp_entry_prio, rsp_last);
   end

   // watchdog on cycles with no request or response taken
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench: errors");
      $finish;
   end

endmodule
